>>> rtl/gspd_pkg.sv
`timescale 1ns / 1ps
package gspd_pkg;

  localparam int GSPD_MAX_SIDE = 1024;
  localparam int REG_W         = 11;
  localparam int SIDES_W       = 4;
  localparam int ADDR_W        = 4;

  localparam logic [ADDR_W-1:0] ADDR_WIDTH  = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_HEIGHT = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_SIDES  = 4'h8;

  localparam int SIDE_TOP    = 0;
  localparam int SIDE_BOTTOM = 1;
  localparam int SIDE_LEFT   = 2;
  localparam int SIDE_RIGHT  = 3;

  localparam logic [7:0] SHADOW_GAIN = 8'd150;
  localparam int DIV_STEPS = 8;

  typedef struct packed {
    logic load;
    logic div_step;
    logic fac;
    logic att;
    logic mul;
  } gspd_cmd_t;

  localparam logic [7:0] FALLOFF [256] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253, 8'd253,
    8'd252, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd249, 8'd248,
    8'd247, 8'd246, 8'd246, 8'd245, 8'd244, 8'd243, 8'd242, 8'd241,
    8'd240, 8'd240, 8'd239, 8'd238, 8'd237, 8'd235, 8'd234, 8'd233,
    8'd232, 8'd231, 8'd230, 8'd229, 8'd227, 8'd226, 8'd225, 8'd224,
    8'd222, 8'd221, 8'd220, 8'd218, 8'd217, 8'd216, 8'd214, 8'd213,
    8'd211, 8'd210, 8'd208, 8'd207, 8'd206, 8'd204, 8'd202, 8'd201,
    8'd199, 8'd198, 8'd196, 8'd195, 8'd193, 8'd191, 8'd190, 8'd188,
    8'd187, 8'd185, 8'd183, 8'd182, 8'd180, 8'd178, 8'd177, 8'd175,
    8'd173, 8'd172, 8'd170, 8'd168, 8'd166, 8'd165, 8'd163, 8'd161,
    8'd160, 8'd158, 8'd156, 8'd154, 8'd153, 8'd151, 8'd149, 8'd148,
    8'd146, 8'd144, 8'd142, 8'd141, 8'd139, 8'd137, 8'd136, 8'd134,
    8'd132, 8'd131, 8'd129, 8'd127, 8'd126, 8'd124, 8'd122, 8'd121,
    8'd119, 8'd117, 8'd116, 8'd114, 8'd113, 8'd111, 8'd109, 8'd108,
    8'd106, 8'd105, 8'd103, 8'd102, 8'd100, 8'd99,  8'd97,  8'd96,
    8'd94,  8'd93,  8'd91,  8'd90,  8'd88,  8'd87,  8'd86,  8'd84,
    8'd83,  8'd81,  8'd80,  8'd79,  8'd77,  8'd76,  8'd75,  8'd73,
    8'd72,  8'd71,  8'd70,  8'd68,  8'd67,  8'd66,  8'd65,  8'd64,
    8'd62,  8'd61,  8'd60,  8'd59,  8'd58,  8'd57,  8'd56,  8'd55,
    8'd54,  8'd53,  8'd52,  8'd51,  8'd50,  8'd49,  8'd48,  8'd47,
    8'd46,  8'd45,  8'd44,  8'd43,  8'd42,  8'd41,  8'd40,  8'd39,
    8'd39,  8'd38,  8'd37,  8'd36,  8'd35,  8'd35,  8'd34,  8'd33,
    8'd32,  8'd32,  8'd31,  8'd30,  8'd30,  8'd29,  8'd28,  8'd28,
    8'd27,  8'd26,  8'd26,  8'd25,  8'd25,  8'd24,  8'd23,  8'd23,
    8'd22,  8'd22,  8'd21,  8'd21,  8'd20,  8'd20,  8'd19,  8'd19,
    8'd18,  8'd18,  8'd17,  8'd17,  8'd16,  8'd16,  8'd16,  8'd15,
    8'd15,  8'd14,  8'd14,  8'd14,  8'd13,  8'd13,  8'd13,  8'd12,
    8'd12,  8'd12,  8'd11,  8'd11,  8'd11,  8'd10,  8'd10,  8'd10,
    8'd10,  8'd9,   8'd9,   8'd9,   8'd9,   8'd8,   8'd8,   8'd8,
    8'd8,   8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd6,   8'd6,
    8'd6,   8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5
  };

endpackage

>>> rtl/gspd_if.sv
`timescale 1ns / 1ps
interface gspd_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface gspd_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_pixel;
  modport source (output valid, red_out, green_out, blue_out, last_pixel, input ready);
  modport sink (input valid, red_out, green_out, blue_out, last_pixel, output ready);
endinterface

>>> rtl/gradient_shadow_pixel_darkener.sv
`timescale 1ns / 1ps
// Gradient shadow pixel darkener.
// Pixels of a rectangle enter on pix_in in raster order (left to right,
// then top to bottom); one darkened pixel leaves on pix_out per input
// transaction, with last_pixel high on the rectangle's final pixel.
// Both channels use valid/ready; a transaction completes when both are high.
// Configuration (width, height, side flags) is written over the APB port
// at byte addresses 0, 4 and 8; the user must write it only while the
// block is idle, which the block itself does not enforce. After the input
// transaction, the bit-serial position divider takes eight steps (one
// quotient bit per clock, both axes together), then falloff lookup and
// fx*fy product, attenuation, channel multiply; then output valid rises.
// The result is taken on an edge with ready high. One pixel is in flight
// at a time, so ready on pix_in stays low until the result has been taken.
// A stalled receiver holds the result stable in the output registers and
// keeps pix_in blocked.
// Reset clears the controller and the column/row counters; configuration
// returns to width 1, height 1, no sides.
module gradient_shadow_pixel_darkener
  import gspd_pkg::*;
#(
  parameter int MAX_SIDE = GSPD_MAX_SIDE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  gspd_pix_in_if.sink         pix_in,
  gspd_pix_out_if.source      pix_out
);

  logic [REG_W-1:0]   width_q, height_q;
  logic [SIDES_W-1:0] sides_q;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= REG_W'(1);
      height_q <= REG_W'(1);
      sides_q  <= '0;
    end else if (wr_en) begin
      unique case (paddr)
        ADDR_WIDTH:  width_q  <= pwdata[REG_W-1:0];
        ADDR_HEIGHT: height_q <= pwdata[REG_W-1:0];
        ADDR_SIDES:  sides_q  <= pwdata[SIDES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_WIDTH:  prdata = 32'(width_q);
      ADDR_HEIGHT: prdata = 32'(height_q);
      ADDR_SIDES:  prdata = 32'(sides_q);
      default:     prdata = '0;
    endcase
  end

  gspd_cmd_t cmd;

  gspd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .out_valid_o (pix_out.valid),
    .out_ready_i (pix_out.ready),
    .cmd_o       (cmd)
  );

  gspd_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rect_width_i   (width_q),
    .rect_height_i  (height_q),
    .shadow_sides_i (sides_q),
    .red_i          (pix_in.red_in),
    .green_i        (pix_in.green_in),
    .blue_i         (pix_in.blue_in),
    .red_o          (pix_out.red_out),
    .green_o        (pix_out.green_out),
    .blue_o         (pix_out.blue_out),
    .last_o         (pix_out.last_pixel)
  );

endmodule

>>> rtl/gspd_ctrl.sv
`timescale 1ns / 1ps
module gspd_ctrl
  import gspd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gspd_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_FAC  = 6'b000100,
    S_ATT  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  localparam int StepW = $clog2(DIV_STEPS);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == StepW'(DIV_STEPS - 1)) state_d = S_FAC;
      end
      S_FAC: begin
        cmd_o.fac = 1'b1;
        state_d   = S_ATT;
      end
      S_ATT: begin
        cmd_o.att = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> rtl/gspd_dp.sv
`timescale 1ns / 1ps
module gspd_dp
  import gspd_pkg::*;
#(
  parameter int MAX_SIDE = GSPD_MAX_SIDE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gspd_cmd_t          cmd_i,
  input  logic [REG_W-1:0]   rect_width_i,
  input  logic [REG_W-1:0]   rect_height_i,
  input  logic [SIDES_W-1:0] shadow_sides_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic               last_o
);

  localparam int CW   = $clog2(MAX_SIDE);
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CMPW = (SW > REG_W) ? SW : REG_W;
  localparam int NW   = CW + 8;

  logic [CW-1:0] col_q, row_q;
  logic [CW-1:0] wm1, hm1, cx, cy;
  logic          col_end, row_end;

  // clamp size to 1..MAX_SIDE, return size-1
  function automatic logic [CW-1:0] size_m1(input logic [REG_W-1:0] s);
    logic [CMPW-1:0] se, c;
    se = CMPW'(s);
    if (se == '0) c = CMPW'(1);
    else if (se > CMPW'(MAX_SIDE)) c = CMPW'(MAX_SIDE);
    else c = se;
    return CW'(c - CMPW'(1));
  endfunction

  assign wm1     = size_m1(rect_width_i);
  assign hm1     = size_m1(rect_height_i);
  assign col_end = (col_q >= wm1);
  assign row_end = (row_q >= hm1);
  assign cx      = col_end ? wm1 : col_q;
  assign cy      = row_end ? hm1 : row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // restoring dividers, one quotient bit per step, both axes side by side
  logic [NW-1:0] rem_x_q, rem_y_q, dsh_x_q, dsh_y_q;
  logic [7:0]    kx_q, ky_q;
  logic [7:0]    r_q, g_q, b_q;
  logic          last_q;
  logic          gex, gey;

  assign gex = (rem_x_q >= dsh_x_q);
  assign gey = (rem_y_q >= dsh_y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_x_q <= {cx, 8'd0} - NW'(cx);
      rem_y_q <= {cy, 8'd0} - NW'(cy);
      dsh_x_q <= {1'b0, wm1, 7'd0};
      dsh_y_q <= {1'b0, hm1, 7'd0};
      r_q     <= red_i;
      g_q     <= green_i;
      b_q     <= blue_i;
      last_q  <= col_end & row_end;
    end else if (cmd_i.div_step) begin
      if (gex) rem_x_q <= rem_x_q - dsh_x_q;
      if (gey) rem_y_q <= rem_y_q - dsh_y_q;
      dsh_x_q <= dsh_x_q >> 1;
      dsh_y_q <= dsh_y_q >> 1;
      kx_q    <= {kx_q[6:0], gex};
      ky_q    <= {ky_q[6:0], gey};
    end
  end

  logic [7:0]  fx, fy;
  logic [15:0] prod_q;
  logic [23:0] scaled;
  logic [7:0]  att_q;

  always_comb begin
    if (shadow_sides_i[SIDE_TOP])         fy = FALLOFF[~ky_q];
    else if (shadow_sides_i[SIDE_BOTTOM]) fy = FALLOFF[ky_q];
    else                                  fy = 8'd255;
    if (shadow_sides_i[SIDE_LEFT])        fx = FALLOFF[~kx_q];
    else if (shadow_sides_i[SIDE_RIGHT])  fx = FALLOFF[kx_q];
    else                                  fx = 8'd255;
  end

  assign scaled = prod_q * SHADOW_GAIN;

  logic [15:0] rm, gm, bm;
  assign rm = r_q * att_q;
  assign gm = g_q * att_q;
  assign bm = b_q * att_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fac) prod_q <= fx * fy;
    if (cmd_i.att) att_q  <= 8'd255 - scaled[23:16];
    if (cmd_i.mul) begin
      red_o   <= rm[15:8];
      green_o <= gm[15:8];
      blue_o  <= bm[15:8];
      last_o  <= last_q;
    end
  end

endmodule

>>> rtl/gspd_checker.sv
`timescale 1ns / 1ps
module gspd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out
);

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a pixel is in flight");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(red_out)))
    else $error("stalled result changed");

endmodule

bind gradient_shadow_pixel_darkener gspd_checker u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red_out   (pix_out.red_out)
);

>>> tb/tb_gradient_shadow_pixel_darkener.sv
`timescale 1ns / 1ps
// Scoreboard: tracks the raster position and the shadow configuration,
// predicts the darkened pixel for each accepted input and checks results
// in order.
class shadow_scoreboard;
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } shaded_pixel_t;

  shaded_pixel_t pending_q[$];
  int unsigned   width_reg  = 1;
  int unsigned   height_reg = 1;
  logic [3:0]    sides_reg  = '0;
  int unsigned   column_pos = 0;
  int unsigned   row_pos    = 0;
  int            errors     = 0;

  function int unsigned clamp_side(int unsigned s);
    if (s < 1) return 1;
    if (s > gspd_pkg::GSPD_MAX_SIDE) return gspd_pkg::GSPD_MAX_SIDE;
    return s;
  endfunction

  function int unsigned scale_to_byte(int unsigned pos, int unsigned size);
    if (size <= 1) return 255;
    return ((255 * pos) / (size - 1)) & 255;
  endfunction

  function int unsigned edge_gain(int unsigned k, logic near_side, logic far_side);
    if (near_side) return gspd_pkg::FALLOFF[255 - k];
    if (far_side) return gspd_pkg::FALLOFF[k];
    return 255;
  endfunction

  // Accepted input pixel: compute the shaded result and advance the raster.
  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, cx, cy, fx, fy, atten;
    logic col_end, row_end;
    shaded_pixel_t px;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    col_end = column_pos >= w - 1;
    row_end = row_pos >= h - 1;
    cx = col_end ? w - 1 : column_pos;
    cy = row_end ? h - 1 : row_pos;
    fy = edge_gain(scale_to_byte(cy, h), sides_reg[gspd_pkg::SIDE_TOP],
                   sides_reg[gspd_pkg::SIDE_BOTTOM]);
    fx = edge_gain(scale_to_byte(cx, w), sides_reg[gspd_pkg::SIDE_LEFT],
                   sides_reg[gspd_pkg::SIDE_RIGHT]);
    atten = 255 - (fx * fy * 150) / 65536;
    px.red   = 8'((r * atten) / 256);
    px.green = 8'((g * atten) / 256);
    px.blue  = 8'((b * atten) / 256);
    px.last  = col_end && row_end;
    pending_q.push_back(px);
    if (col_end) begin
      column_pos = 0;
      row_pos = row_end ? 0 : row_pos + 1;
    end else begin
      column_pos++;
    end
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    shaded_pixel_t px;
    if (pending_q.size() == 0) begin
      report_mismatch("result with no pixel pending");
      return;
    end
    px = pending_q.pop_front();
    if (r !== px.red) report_mismatch($sformatf("red %0d exp %0d", r, px.red));
    if (g !== px.green) report_mismatch($sformatf("green %0d exp %0d", g, px.green));
    if (b !== px.blue) report_mismatch($sformatf("blue %0d exp %0d", b, px.blue));
    if (last !== px.last) report_mismatch($sformatf("last %0d exp %0d", last, px.last));
  endtask
endclass

module tb_gradient_shadow_pixel_darkener;
  import gspd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  gspd_pix_in_if  pix_in ();
  gspd_pix_out_if pix_out ();

  gradient_shadow_pixel_darkener i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .pix_in (pix_in.sink),
    .pix_out(pix_out.source)
  );

  shadow_scoreboard shadow_sb = new();

  // idle rates in percent; tweaked per phase
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 84;
  int unsigned quiet_cycles  = 0;
  bit          timed_out     = 1'b0;

  always #5 clk_i = ~clk_i;

  initial begin
    pix_in.valid    = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_out.ready   = 1'b0;
  end

  // receiver: random stalls, checks on every output transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_out.valid && pix_out.ready)
        shadow_sb.check_pixel(pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                              pix_out.last_pixel);
      pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired");
      $display("tb_gradient_shadow_pixel_darkener failed");
      $finish;
    end
  end

  // APB write: setup then access; pready is tied high in the block
  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (shadow_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // idle-only write; keeps the predictor in step
  task automatic set_shadow(int unsigned w, int unsigned h, logic [3:0] sides);
    wait_drained();
    apb_write(ADDR_WIDTH, 32'(w));
    apb_write(ADDR_HEIGHT, 32'(h));
    apb_write(ADDR_SIDES, 32'(sides));
    shadow_sb.width_reg  = w & 11'h7ff;
    shadow_sb.height_reg = h & 11'h7ff;
    shadow_sb.sides_reg  = sides;
  endtask

  // one input transaction; valid stays high across back-to-back pixels
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid    <= 1'b1;
    pix_in.red_in   <= r;
    pix_in.green_in <= g;
    pix_in.blue_in  <= b;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    shadow_sb.note_pixel(r, g, b);
  endtask

  task automatic end_burst();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end_burst();
  endtask

  task automatic random_shape();
    int unsigned w, h;
    // mostly small rectangles, now and then a full-size side
    w = ($urandom_range(9) == 0) ? 1024 : $urandom_range(1, 12);
    h = ($urandom_range(9) == 0) ? 1024 : $urandom_range(1, 12);
    if ($urandom_range(19) == 0) w = $urandom_range(2047);
    set_shadow(w, h, 4'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config (1x1), channel extremes
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h80, 8'h7f, 8'h01);
    end_burst();
    // 3x2 with every side, incl. both flags on one axis
    set_shadow(3, 2, 4'b0101);
    send_random(6);
    set_shadow(3, 2, 4'b1010);
    send_random(6);
    set_shadow(2, 3, 4'b1111);
    send_random(4);
    // shrink mid-rectangle: counters beyond the new size
    set_shadow(2, 2, 4'b0000);
    send_pixel(8'hff, 8'h00, 8'hff);
    end_burst();
    // sizes of 0 and above the maximum are clamped
    set_shadow(0, 2047, 4'b0011);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h55, 8'haa, 8'h55);
    end_burst();

    // pause until every expected result has come
    set_shadow(1024, 1, 4'b1100);
    send_random(5);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 27 : 0;
      for (int blk = 0; blk < 10; blk++) begin
        random_shape();
        send_random($urandom_range(20, 50));
      end
    end

    wait_drained();
    if (shadow_sb.errors == 0)
      $display("tb_gradient_shadow_pixel_darkener passed");
    else
      $display("tb_gradient_shadow_pixel_darkener failed");
    $finish;
  end
endmodule
